>>> rtl/core/stli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine table interpolator package
// Word layout of the sine ROM and the elaboration-time sine generator.
// ----------------------------------------------------------------------------
package stli_pkg;

  localparam int WORD_BITS = 16;
  localparam int SIGN_BIT  = 15;
  localparam int Q_FRAC    = 62;
  localparam int TERMS     = 12;

  localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C235;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // (a * b) >> 62, kept to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[Q_FRAC +: 64];
  endfunction

  // term / ((2k)(2k+1))
  function automatic logic [63:0] taylor_div(input logic [63:0] v, input int k);
    case (k)
      1:       return v / 64'd6;
      2:       return v / 64'd20;
      3:       return v / 64'd42;
      4:       return v / 64'd72;
      5:       return v / 64'd110;
      6:       return v / 64'd156;
      7:       return v / 64'd210;
      8:       return v / 64'd272;
      9:       return v / 64'd342;
      10:      return v / 64'd420;
      11:      return v / 64'd506;
      default: return v / 64'd600;
    endcase
  endfunction

  // Sign-magnitude sine of x (Q2.62, below 4), magnitude floored and clamped
  function automatic logic [WORD_BITS-1:0] sine_word(input logic [63:0] x_in,
                                                     input int frac_bits);
    logic        neg;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic [63:0] mag_max;
    neg = 1'b0;
    x   = x_in;
    if (x >= PI_Q62) begin
      neg = 1'b1;
      x   = x - PI_Q62;
    end
    if (x > HALF_PI_Q62) begin
      x = PI_Q62 - x;
    end
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= TERMS; k++) begin
      term = taylor_div(mul_q62(term, x2), k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    mag     = sum >> (Q_FRAC - frac_bits);
    mag_max = (64'd1 << frac_bits) - 64'd1;
    if (mag > mag_max) begin
      mag = mag_max;
    end
    return {neg, mag[WORD_BITS-2:0]};
  endfunction

endpackage

>>> rtl/core/stli_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine ROM, two banks
// Even and odd entries in separate banks so that neighbouring entries i and
// i+1 are read in the same cycle. Read data registered.
// ----------------------------------------------------------------------------
module stli_rom #(
  parameter int TABLE_INDEX_BITS = 12,
  parameter int RESULT_FRAC_BITS = 15
) (
  input  logic                               clk,
  input  logic [TABLE_INDEX_BITS-2:0]        even_addr,
  input  logic [TABLE_INDEX_BITS-2:0]        odd_addr,
  output logic [stli_pkg::WORD_BITS-1:0]     even_data,
  output logic [stli_pkg::WORD_BITS-1:0]     odd_data
);

  localparam int BANK_DEPTH = 1 << (TABLE_INDEX_BITS - 1);
  localparam int SHIFT      = 64 - TABLE_INDEX_BITS;

  logic [stli_pkg::WORD_BITS-1:0] even_rom [BANK_DEPTH];
  logic [stli_pkg::WORD_BITS-1:0] odd_rom  [BANK_DEPTH];

  for (genvar j = 0; j < BANK_DEPTH; j++) begin : g_word
    localparam logic [stli_pkg::WORD_BITS-1:0] EvenWord =
      stli_pkg::sine_word(64'(2 * j) << SHIFT, RESULT_FRAC_BITS);
    localparam logic [stli_pkg::WORD_BITS-1:0] OddWord =
      stli_pkg::sine_word(64'(2 * j + 1) << SHIFT, RESULT_FRAC_BITS);
    assign even_rom[j] = EvenWord;
    assign odd_rom[j]  = OddWord;
  end

  always_ff @(posedge clk) begin
    even_data <= even_rom[even_addr];
    odd_data  <= odd_rom[odd_addr];
  end

endmodule

>>> rtl/core/sine_table_linear_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine table linear interpolator
// Sine of an unsigned fixed-point angle by table lookup and linear
// interpolation, returned as sign and magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   Drive angle and raise start; the beat is taken at the clock edge where
//   start is high and busy is low. busy stays low, so a new angle may be
//   given every cycle.
//   Each beat gives one result beat: done is high for one cycle with
//   sine_magnitude, sine_negative and out_of_range valid in that cycle.
//   Path: ROM read, weighting multiply, sum and output register.
//   Throughput: one angle per cycle, set by the two-bank ROM which yields
//   both neighbouring entries in a single read.
//   Angles past the last table point give out_of_range with a zero result.
//   Reset empties the pipeline; beats in flight are dropped. The ROM holds
//   fixed contents and needs no fill.
//   The receiver cannot stall: done is a strobe and each result is shown
//   once.
// ----------------------------------------------------------------------------
module sine_table_linear_interpolator_unit #(
  parameter int TABLE_INDEX_BITS = 12,
  parameter int INTERP_BITS      = 3,
  parameter int RESULT_FRAC_BITS = 15
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [TABLE_INDEX_BITS+INTERP_BITS-1:0] angle,
  output logic                                    done,
  output logic [RESULT_FRAC_BITS-1:0]             sine_magnitude,
  output logic                                    sine_negative,
  output logic                                    out_of_range
);

  localparam int AW = TABLE_INDEX_BITS + INTERP_BITS;
  localparam int HW = TABLE_INDEX_BITS - 1;
  localparam int WW = INTERP_BITS + 1;
  localparam int PW = RESULT_FRAC_BITS + WW;
  localparam int SW = PW + 1;
  localparam int DW = stli_pkg::WORD_BITS;

  // stage 0: address
  logic [TABLE_INDEX_BITS-1:0] idx0;
  logic [INTERP_BITS-1:0]      r0;
  logic [HW-1:0]               even_addr;
  logic [HW-1:0]               odd_addr;
  logic                        accept;

  // stage 1: ROM data
  logic                   v1;
  logic [INTERP_BITS-1:0] r1;
  logic                   odd1;
  logic                   last1;
  logic                   err1;
  logic [DW-1:0]          even_data;
  logic [DW-1:0]          odd_data;
  logic [DW-1:0]          ent_a;
  logic [DW-1:0]          ent_b;
  logic [WW-1:0]          wa;
  logic [WW-1:0]          wb;

  // stage 2: products
  logic          v2;
  logic [PW-1:0] pa;
  logic [PW-1:0] pb;
  logic          na2;
  logic          nb2;
  logic          last2;
  logic          err2;
  logic [DW-1:0] word2;

  logic signed [SW-1:0] sa;
  logic signed [SW-1:0] sb;
  logic signed [SW-1:0] sum2;
  logic        [SW-1:0] abs2;
  logic                 neg2;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign idx0   = angle[AW-1:INTERP_BITS];
  assign r0     = angle[INTERP_BITS-1:0];

  // entry i+1 sits in the other bank; for odd i it is the next even row
  assign odd_addr  = idx0[TABLE_INDEX_BITS-1:1];
  assign even_addr = idx0[0] ? idx0[TABLE_INDEX_BITS-1:1] + HW'(1)
                             : idx0[TABLE_INDEX_BITS-1:1];

  stli_rom #(
    .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_rom (
    .clk       (clk),
    .even_addr (even_addr),
    .odd_addr  (odd_addr),
    .even_data (even_data),
    .odd_data  (odd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    r1    <= r0;
    odd1  <= idx0[0];
    last1 <= (idx0 == '1);
    err1  <= (idx0 == '1) && (r0 != '0);
  end

  assign ent_a = odd1 ? odd_data : even_data;
  assign ent_b = odd1 ? even_data : odd_data;
  assign wa    = {1'b1, {INTERP_BITS{1'b0}}} - {1'b0, r1};
  assign wb    = {1'b0, r1};

  always_ff @(posedge clk) begin
    pa    <= PW'(wa) * PW'(ent_a[RESULT_FRAC_BITS-1:0]);
    pb    <= PW'(wb) * PW'(ent_b[RESULT_FRAC_BITS-1:0]);
    na2   <= ent_a[stli_pkg::SIGN_BIT];
    nb2   <= ent_b[stli_pkg::SIGN_BIT];
    last2 <= last1;
    err2  <= err1;
    word2 <= ent_a;
  end

  always_comb begin
    sa   = na2 ? -$signed({1'b0, pa}) : $signed({1'b0, pa});
    sb   = nb2 ? -$signed({1'b0, pb}) : $signed({1'b0, pb});
    sum2 = sa + sb;
    neg2 = sum2[SW-1];
    abs2 = neg2 ? SW'(-sum2) : SW'(sum2);
  end

  always_ff @(posedge clk) begin
    if (err2) begin
      sine_magnitude <= '0;
      sine_negative  <= 1'b0;
      out_of_range   <= 1'b1;
    end else if (last2) begin
      sine_magnitude <= word2[RESULT_FRAC_BITS-1:0];
      sine_negative  <= word2[stli_pkg::SIGN_BIT];
      out_of_range   <= 1'b0;
    end else begin
      sine_magnitude <= abs2[INTERP_BITS +: RESULT_FRAC_BITS];
      sine_negative  <= neg2;
      out_of_range   <= 1'b0;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without accepted beat");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> sine_magnitude == '0 && !sine_negative)
    else $error("range error with non-zero result");

  a_range_cause: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> $past(angle[AW-1:INTERP_BITS] == '1, 3))
    else $error("range error below last table point");

endmodule
